// File: hdl/brs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_pkg
// Shared types and constants for the block reverse stream unit.
// ----------------------------------------------------------------------------
package brs_pkg;

    localparam int DATA_W      = 32;  // element width
    localparam int CNT_W       = 7;   // group size register and run counters
    localparam int MAX_GROUP_D = 64;  // default group buffer depth

    localparam logic [CNT_W-1:0] GROUP_SIZE_RST = 7'd4;

    // register indexes (paddr[2] selects the register)
    localparam logic REG_GROUP_SIZE = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // input transfer this cycle
        logic read;     // fetch the current run element
        logic advance;  // output transfer this cycle
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic flush;    // accepted element closes a run
        logic run_end;  // current element is the last of the run
    } dp_status_t;

endpackage

// File: hdl/brs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_ctrl
// Sequencer: takes elements while idle, then reads out each flushed run
// one element at a time through the registered buffer read.
// ----------------------------------------------------------------------------
module brs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output brs_pkg::dp_cmd_t      cmd,
    input  brs_pkg::dp_status_t   status
);

    brs_pkg::state_t state_reg;
    brs_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= brs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.accept  = 1'b0;
        cmd.read    = 1'b0;
        cmd.advance = 1'b0;
        case (state_reg)
            brs_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && status.flush) begin
                    state_next = brs_pkg::ST_READ;
                end
            end
            brs_pkg::ST_READ: begin
                cmd.read   = 1'b1;
                state_next = brs_pkg::ST_SEND;
            end
            brs_pkg::ST_SEND: begin
                m_tvalid    = 1'b1;
                cmd.advance = m_tready;
                // hold the element until the downstream transfer
                if (m_tready) begin
                    state_next = status.run_end ? brs_pkg::ST_IDLE : brs_pkg::ST_READ;
                end
            end
            default: begin
                state_next = brs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/brs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brs_dp
// Group buffer, fill and run counters, read addressing and output register.
// ----------------------------------------------------------------------------
module brs_dp #(
    parameter int MAX_GROUP = brs_pkg::MAX_GROUP_D
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [brs_pkg::CNT_W-1:0]     group_size,
    input  logic [brs_pkg::DATA_W-1:0]    in_value,
    input  logic                          in_last,
    input  brs_pkg::dp_cmd_t              cmd,
    output brs_pkg::dp_status_t           status,
    output logic [brs_pkg::DATA_W-1:0]    out_value,
    output logic                          out_run_last,
    output logic                          out_list_last
);

    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam logic [brs_pkg::CNT_W-1:0] MAX_CNT = brs_pkg::CNT_W'(MAX_GROUP);
    localparam logic [brs_pkg::CNT_W-1:0] ONE     = brs_pkg::CNT_W'(1);

    logic [brs_pkg::DATA_W-1:0] mem [MAX_GROUP];

    logic [brs_pkg::CNT_W-1:0]  fill_reg, fill_next;
    logic [brs_pkg::CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [brs_pkg::CNT_W-1:0]  len_reg;
    logic                       rev_reg;
    logic                       last_reg;
    logic [brs_pkg::DATA_W-1:0] rd_data_reg;
    logic                       run_last_reg;
    logic                       list_last_reg;

    logic [brs_pkg::CNT_W-1:0]  size_eff;
    logic [brs_pkg::CNT_W-1:0]  fill_clamp;
    logic [brs_pkg::CNT_W-1:0]  n_held;
    logic                       full;
    logic [brs_pkg::CNT_W-1:0]  rd_idx;
    logic                       at_end;

    always_comb begin
        if (group_size == '0) begin
            size_eff = ONE;
        end else if (group_size > MAX_CNT) begin
            size_eff = MAX_CNT;
        end else begin
            size_eff = group_size;
        end
        fill_clamp = (fill_reg >= MAX_CNT) ? (MAX_CNT - ONE) : fill_reg;
        n_held     = fill_clamp + ONE;
        full       = (n_held >= size_eff);
        rd_idx     = rev_reg ? (len_reg - ONE - cnt_reg) : cnt_reg;
        at_end     = ((cnt_reg + ONE) == len_reg);
    end

    assign status.flush   = full || in_last;
    assign status.run_end = at_end;

    // buffer write on input transfer, registered read for the output
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mem[fill_clamp[AW-1:0]] <= in_value;
        end
        if (cmd.read) begin
            rd_data_reg   <= mem[rd_idx[AW-1:0]];
            run_last_reg  <= at_end;
            list_last_reg <= at_end && last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && status.flush) begin
            len_reg  <= n_held;
            rev_reg  <= full;
            last_reg <= in_last;
        end
    end

    always_comb begin
        fill_next = fill_reg;
        cnt_next  = cnt_reg;
        if (cmd.accept) begin
            fill_next = status.flush ? '0 : n_held;
            cnt_next  = '0;
        end else if (cmd.advance) begin
            cnt_next = cnt_reg + ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            fill_reg <= fill_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign out_value     = rd_data_reg;
    assign out_run_last  = run_last_reg;
    assign out_list_last = list_last_reg;

endmodule

// File: hdl/block_reverse_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_reverse_stream
// Gathers 32-bit elements into groups of a programmable size and emits each
// full group in reverse order; a short tail at end of list leaves in order.
//
//   channel   | direction | contents
//   s_*       | in        | tdata: value, tlast: end_of_list
//   m_*       | out       | tdata: out_value, tlast: run_last, tuser: list_last
//   APB       | in/out    | 0x0 group_size (7 bits, reset 4)
//
// An element that does not close a run is written to the buffer. An
// element that closes a run is written too; then each of the run's n
// elements goes through a buffer read, then an output transfer. No input
// is taken while a run is being sent. A stall on m_tready holds the
// current output. Reset is synchronous; it clears the fill count and the
// sequencer, the buffer contents are not cleared.
// ----------------------------------------------------------------------------
module block_reverse_stream #(
    parameter int MAX_GROUP = brs_pkg::MAX_GROUP_D
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [brs_pkg::DATA_W-1:0]  s_tdata,   // [31:0] value
    input  logic                        s_tlast,
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [brs_pkg::DATA_W-1:0]  m_tdata,   // [31:0] out_value
    output logic                        m_tlast,
    output logic                        m_tuser,   // [0] list_last
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [brs_pkg::CNT_W-1:0] group_size_reg;
    brs_pkg::dp_cmd_t          cmd;
    brs_pkg::dp_status_t       status;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_size_reg <= brs_pkg::GROUP_SIZE_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == brs_pkg::REG_GROUP_SIZE) begin
            group_size_reg <= pwdata[brs_pkg::CNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == brs_pkg::REG_GROUP_SIZE) begin
            prdata = {{(32 - brs_pkg::CNT_W){1'b0}}, group_size_reg};
        end
    end

    brs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    brs_dp #(
        .MAX_GROUP (MAX_GROUP)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .group_size    (group_size_reg),
        .in_value      (s_tdata),
        .in_last       (s_tlast),
        .cmd           (cmd),
        .status        (status),
        .out_value     (m_tdata),
        .out_run_last  (m_tlast),
        .out_list_last (m_tuser)
    );

endmodule
